>>> src/bbr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, reciprocal table and controller/datapath interface types for the row box blur.
package bbr_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_RADIUS = 31;
	localparam int WIN_AW     = 6;   // window store holds 64 pixels
	localparam int RECIP_SH   = 21;  // fixed-point shift of the reciprocal table

	// Configuration register indexes
	localparam logic CFG_RADIUS = 1'b0;
	localparam logic CFG_WIDTH  = 1'b1;

	// ceil(2^21 / (2r+1)) for r = 0 .. 31; exact truncated quotient for 14-bit sums
	localparam logic [21:0] RECIP [32] = '{
		22'd2097152, 22'd699051, 22'd419431, 22'd299594,
		22'd233017,  22'd190651, 22'd161320, 22'd139811,
		22'd123362,  22'd110377, 22'd99865,  22'd91181,
		22'd83887,   22'd77673,  22'd72316,  22'd67651,
		22'd63551,   22'd59919,  22'd56680,  22'd53774,
		22'd51151,   22'd48771,  22'd46604,  22'd44621,
		22'd42800,   22'd41121,  22'd39569,  22'd38131,
		22'd36793,   22'd35545,  22'd34380,  22'd33289
	};

	typedef struct packed {
		logic              wr_en;
		logic              wr_first;
		logic [WIN_AW-1:0] wr_addr;
		logic              rd_en;
		logic              rd_sub;
		logic              rd_first;
		logic [WIN_AW-1:0] rd_addr;
		logic              acc_clr;
		logic              mul_en;
		logic [4:0]        radius;
		logic              out_load;
		logic              out_last;
		logic [11:0]       out_col;
		logic [11:0]       out_row;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

>>> src/box_blur_row_filter.sv
`timescale 1ns / 1ps
// After the pixel that releases it is accepted, a result beat is formed through CHECK, SUB, ADD,
// DRAIN and MUL and loaded in EMIT; column 0 of a row sums its whole window in FULL instead.
// A mid-row result takes five steps (SUB, ADD, DRAIN, MUL, EMIT) and a recheck, and a new
// pixel is taken only in IDLE, once every result the last one releases has been loaded.
// Column 0 reads 2r+1 pixels instead of two; a full output register stalls.
// Reset (arst_n low, asynchronous) sets radius 1, width 640 and clears the row counters.
// Top level of the row box blur: a controller sequences a running-sum datapath.
module box_blur_row_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pixel_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] blurred_pixel,
	output logic [11:0] column_index,
	output logic [11:0] row_index,
	output logic        last_of_run
);

	// Command and status between the sequencer and the datapath. Each result is formed
	// from the previous window sum by removing the pixel that left the window and adding
	// the one that entered it; the first column of a row sums its whole clamped window.
	bbr_pkg::dp_cmd_t cmd;
	bbr_pkg::dp_sts_t sts;

	// The controller holds the configuration, the column and row counters and decides
	// how many results each accepted beat releases.
	bbr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	// The datapath keeps the last 64 pixels, the four channel sums, divides them by
	// 2r+1 through a reciprocal multiply and holds the result beat in an output register,
	// so the next pixel may be accepted while a result beat waits to be taken.
	bbr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.pixel_in      (pixel_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blurred_pixel (blurred_pixel),
		.column_index  (column_index),
		.row_index     (row_index),
		.last_of_run   (last_of_run)
	);

endmodule

>>> src/bbr_datapath.sv
`timescale 1ns / 1ps
// Datapath: window store, running channel sums, reciprocal multiply and output register.
module bbr_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  bbr_pkg::dp_cmd_t cmd,
	output bbr_pkg::dp_sts_t sts,
	input  logic [31:0]      pixel_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      blurred_pixel,
	output logic [11:0]      column_index,
	output logic [11:0]      row_index,
	output logic             last_of_run
);

	logic [31:0] win_mem [2**bbr_pkg::WIN_AW];
	logic [31:0] first_q;
	logic [31:0] rdata_s1;
	logic        rd_en_s1;
	logic        rd_sub_s1;
	logic        rd_first_s1;
	logic [13:0] sum_q [4];
	logic [35:0] prod_s2 [4];
	logic        out_valid_q;
	logic [31:0] pix_rd;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			win_mem[cmd.wr_addr] <= pixel_in;
		end
		rdata_s1 <= win_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_first) begin
			first_q <= pixel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_sub_s1   <= cmd.rd_sub;
		rd_first_s1 <= cmd.rd_first;
	end

	assign pix_rd = rd_first_s1 ? first_q : rdata_s1;

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 4; ch++) begin
			if (cmd.acc_clr) begin
				sum_q[ch] <= '0;
			end else if (rd_en_s1) begin
				if (rd_sub_s1) begin
					sum_q[ch] <= sum_q[ch] - {6'b0, pix_rd[31-8*ch -: 8]};
				end else begin
					sum_q[ch] <= sum_q[ch] + {6'b0, pix_rd[31-8*ch -: 8]};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			for (int ch = 0; ch < 4; ch++) begin
				prod_s2[ch] <= {22'b0, sum_q[ch]} * {14'b0, bbr_pkg::RECIP[cmd.radius]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int ch = 0; ch < 4; ch++) begin
				blurred_pixel[31-8*ch -: 8] <= prod_s2[ch][bbr_pkg::RECIP_SH +: 8];
			end
			column_index <= cmd.out_col;
			row_index    <= cmd.out_row;
			last_of_run  <= cmd.out_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

>>> src/bbr_ctrl.sv
`timescale 1ns / 1ps
// Controller: configuration registers, row counters and the per-result sequencing.
module bbr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic             cfg_index,
	input  logic [12:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	output bbr_pkg::dp_cmd_t cmd,
	input  bbr_pkg::dp_sts_t sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_FULL  = 3'd2;
	localparam logic [2:0] S_SUB   = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_MUL   = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0]  state_q;
	logic [4:0]  blur_radius_q;
	logic [12:0] row_width_q;
	logic [11:0] in_count_q;
	logic [11:0] out_count_q;
	logic [11:0] row_count_q;
	logic [11:0] k_q;
	logic        last_q;
	logic [5:0]  n_q;
	logic [5:0]  t_q;

	logic [4:0]  rad;
	logic [11:0] wm1;
	logic [12:0] oc13;
	logic        more;
	logic        next_ok;
	logic [13:0] col;
	logic [11:0] col_c;

	always_comb begin
		rad = (blur_radius_q > 5'(bbr_pkg::MAX_RADIUS)) ? 5'(bbr_pkg::MAX_RADIUS) : blur_radius_q;
		if (row_width_q == 13'd0) begin
			wm1 = 12'd0;
		end else if (row_width_q > 13'(bbr_pkg::MAX_WIDTH)) begin
			wm1 = 12'(bbr_pkg::MAX_WIDTH - 1);
		end else begin
			wm1 = 12'(row_width_q - 13'd1);
		end
		oc13 = {1'b0, out_count_q};
		if (last_q) begin
			more    = (oc13 <= {1'b0, wm1}) && (n_q < 6'd32);
			next_ok = (oc13 + 13'd1 <= {1'b0, wm1}) && (n_q < 6'd31);
		end else begin
			more    = (oc13 + {8'b0, rad} <= {1'b0, k_q}) && (n_q < 6'd32);
			next_ok = (oc13 + 13'd1 + {8'b0, rad} <= {1'b0, k_q}) && (n_q < 6'd31);
		end
	end

	// Column of the pixel to fetch, then clamped to the row
	always_comb begin
		case (state_q)
			S_FULL:  col = {8'b0, t_q} - {9'b0, rad};
			S_SUB:   col = {2'b0, out_count_q} - 14'd1 - {9'b0, rad};
			S_ADD:   col = {2'b0, out_count_q} + {9'b0, rad};
			default: col = 14'd0;
		endcase
		if (col[13] || col == 14'd0) begin
			col_c = 12'd0;
		end else if (col[12:0] >= {1'b0, wm1}) begin
			col_c = wm1;
		end else begin
			col_c = col[11:0];
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.radius   = rad;
		cmd.wr_addr  = in_count_q[bbr_pkg::WIN_AW-1:0];
		cmd.wr_first = (in_count_q == 12'd0);
		cmd.rd_addr  = col_c[bbr_pkg::WIN_AW-1:0];
		cmd.rd_first = (col_c == 12'd0);
		cmd.out_col  = out_count_q;
		cmd.out_row  = row_count_q;
		cmd.out_last = !next_ok;
		in_ready     = (state_q == S_IDLE);
		case (state_q)
			S_IDLE:  cmd.wr_en = in_valid;
			S_CHECK: cmd.acc_clr = more && (out_count_q == 12'd0);
			S_FULL: begin
				cmd.rd_en = 1'b1;
			end
			S_SUB: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sub = 1'b1;
			end
			S_ADD:   cmd.rd_en = 1'b1;
			S_MUL:   cmd.mul_en = 1'b1;
			S_EMIT:  cmd.out_load = sts.out_free;
			default: cmd.rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			blur_radius_q <= 5'd1;
			row_width_q   <= 13'd640;
			in_count_q    <= '0;
			out_count_q   <= '0;
			row_count_q   <= '0;
			k_q           <= '0;
			last_q        <= 1'b0;
			n_q           <= '0;
			t_q           <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				bbr_pkg::CFG_RADIUS: blur_radius_q <= cfg_data[4:0];
				bbr_pkg::CFG_WIDTH:  row_width_q   <= cfg_data;
				default:             row_width_q   <= row_width_q;
			endcase
			in_count_q  <= '0;
			out_count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						k_q        <= in_count_q;
						last_q     <= (in_count_q >= wm1);
						in_count_q <= (in_count_q >= wm1) ? 12'd0 : in_count_q + 12'd1;
						n_q        <= '0;
						state_q    <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (more) begin
						t_q     <= '0;
						state_q <= (out_count_q == 12'd0) ? S_FULL : S_SUB;
					end else begin
						if (last_q) begin
							out_count_q <= '0;
							row_count_q <= row_count_q + 12'd1;
						end
						state_q <= S_IDLE;
					end
				end
				S_FULL: begin
					t_q <= t_q + 6'd1;
					if (t_q == {rad, 1'b0}) begin
						state_q <= S_DRAIN;
					end
				end
				S_SUB:   state_q <= S_ADD;
				S_ADD:   state_q <= S_DRAIN;
				S_DRAIN: state_q <= S_MUL;
				S_MUL:   state_q <= S_EMIT;
				S_EMIT: begin
					if (sts.out_free) begin
						out_count_q <= out_count_q + 12'd1;
						n_q         <= n_q + 6'd1;
						state_q     <= S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n) n_q <= 6'd32)
		else $error("more than 32 results for one input");
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && !cfg_write_en) |=> state_q == S_CHECK)
		else $error("accepted pixel not followed by a window check");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten while full");
	a_full_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FULL |-> t_q <= {rad, 1'b0})
		else $error("full window sum ran past its span");

endmodule
